// ===== hdl/mmbn_pkg.sv =====
// Package for the min-max block normalizer.
// Holds default sizes, configuration register codes, the sequencer state type and the
// control word that the top level sends to the sample store. No dependencies.
`default_nettype none

package mmbn_pkg;

    localparam int MAX_LEN_DEF     = 32;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int CFG_IDX_W = 1;

    localparam int OUT_MIN_RESET = 0;
    localparam int OUT_MAX_RESET = 256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OUT_MIN = 1'b0,
        CFG_OUT_MAX = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FETCH,
        ST_MULT,
        ST_DIV,
        ST_PUSH
    } state_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic fetch;
    } store_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/mmbn_store.sv =====
// Sample store of the min-max block normalizer: block memory, fill count and the
// running high and low of the current block.
// Depends on mmbn_pkg.
`default_nettype none

module mmbn_store #(
    parameter int MAX_LEN     = mmbn_pkg::MAX_LEN_DEF,
    parameter int SAMPLE_BITS = mmbn_pkg::SAMPLE_BITS_DEF,
    localparam int ADDR_W     = $clog2(MAX_LEN),
    localparam int CNT_W      = $clog2(MAX_LEN + 1)
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire mmbn_pkg::store_ctrl_t     ctrl,
    input  wire logic [SAMPLE_BITS-1:0]    sample,
    input  wire logic [ADDR_W-1:0]         rd_addr,
    output logic      [SAMPLE_BITS-1:0]    rd_data,
    output logic      [CNT_W-1:0]          count,
    output logic      [SAMPLE_BITS-1:0]    high,
    output logic      [SAMPLE_BITS-1:0]    low
);

    logic [SAMPLE_BITS-1:0] mem [MAX_LEN];
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [SAMPLE_BITS-1:0] high_reg, high_next;
    logic [SAMPLE_BITS-1:0] low_reg, low_next;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            mem[count_reg[ADDR_W-1:0]] <= sample;
        end
        if (ctrl.fetch)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        high_next  = high_reg;
        low_next   = low_reg;
        if (ctrl.clear)
        begin
            count_next = '0;
        end
        else if (ctrl.load)
        begin
            count_next = count_reg + CNT_W'(1);
            if (count_reg == '0)
            begin
                high_next = sample;
                low_next  = sample;
            end
            else
            begin
                if ($signed(sample) > $signed(high_reg))
                begin
                    high_next = sample;
                end
                if ($signed(sample) < $signed(low_reg))
                begin
                    low_next = sample;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            high_reg  <= '0;
            low_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            high_reg  <= high_next;
            low_reg   <= low_next;
        end
    end

    assign rd_data = rd_data_reg;
    assign count   = count_reg;
    assign high    = high_reg;
    assign low     = low_reg;

endmodule

`default_nettype wire

// ===== hdl/mmbn_serial_div.sv =====
// Bit-serial restoring divider of the min-max block normalizer.
// Divides a 2W-bit dividend by a W-bit divisor whose quotient fits in W bits, one bit per cycle.
// Depends on mmbn_pkg for the default of the width W.
`default_nettype none

module mmbn_serial_div #(
    parameter int W = mmbn_pkg::SAMPLE_BITS_DEF + 1,
    localparam int CW = $clog2(W + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [2*W-1:0]   dividend,
    input  wire logic [W-1:0]     divisor,
    output logic                  done,
    output logic      [W-1:0]     quotient
);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  dvd_reg, dvd_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W+1:0]  diff;
    logic          fits;

    // The partial remainder stays below the divisor, so the trial difference needs two
    // extra bits: one for the shifted-in dividend bit and one for the borrow.
    assign diff = {1'b0, rem_reg, dvd_reg[W-1]} - {2'b00, dvs_reg};
    assign fits = !diff[W+1];

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend[2*W-1:W];
            dvd_next  = dividend[W-1:0];
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[W-1:0] : {rem_reg[W-2:0], dvd_reg[W-1]};
            dvd_next = {dvd_reg[W-2:0], fits};
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

`default_nettype wire

// ===== hdl/min_max_block_normalizer_top.sv =====
// Top level of the min-max block normalizer: configuration registers, sequencer,
// offset multiply and output word register.
// Depends on mmbn_pkg, mmbn_store and mmbn_serial_div.

// Samples are taken one word per cycle until a word marked last arrives or the store holds
// MAX_LEN samples; the input then stalls while the block is emitted in arrival order. Each
// result passes through one store read, one multiply, SAMPLE_BITS + 1 steps of the
// bit-serial divider and its done flag, and the load of the output register; in a flat
// block no division is done. The output register holds a result while the next one is
// computed, and loading of the next block starts as soon as the last result of a block
// sits in the output register.
`default_nettype none

module min_max_block_normalizer_top #(
    parameter int MAX_LEN     = mmbn_pkg::MAX_LEN_DEF,
    parameter int SAMPLE_BITS = mmbn_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [mmbn_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [SAMPLE_BITS-1:0]           cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [SAMPLE_BITS-1:0]           sample,
    input  wire logic                             last,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic      [SAMPLE_BITS-1:0]           scaled,
    output logic                                  flat,
    output logic      [SAMPLE_BITS-1:0]           block_high,
    output logic      [SAMPLE_BITS-1:0]           block_low,
    output logic                                  end_of_run
);

    localparam int W      = SAMPLE_BITS + 1;
    localparam int ADDR_W = $clog2(MAX_LEN);
    localparam int CNT_W  = $clog2(MAX_LEN + 1);

    logic [SAMPLE_BITS-1:0] out_min_reg;
    logic [SAMPLE_BITS-1:0] out_max_reg;

    mmbn_pkg::state_t       state_reg, state_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    mmbn_pkg::store_ctrl_t  ctrl;

    logic [SAMPLE_BITS-1:0] rd_data;
    logic [CNT_W-1:0]       count;
    logic [SAMPLE_BITS-1:0] high;
    logic [SAMPLE_BITS-1:0] low;

    logic                   block_end;
    logic                   is_flat;
    logic [W-1:0]           range_w;
    logic                   range_neg;
    logic [W-1:0]           mag;
    logic [W-1:0]           span;
    logic [W-1:0]           offset;
    logic [2*W-1:0]         product;
    logic                   div_start;
    logic                   div_done;
    logic [W-1:0]           quotient;
    logic [W-1:0]           q_sel;
    logic [W-1:0]           result_w;
    logic                   is_final;
    logic                   push;

    logic                   out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0] scaled_reg;
    logic                   flat_reg;
    logic [SAMPLE_BITS-1:0] high_out_reg;
    logic [SAMPLE_BITS-1:0] low_out_reg;
    logic                   eor_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_min_reg <= SAMPLE_BITS'(mmbn_pkg::OUT_MIN_RESET);
            out_max_reg <= SAMPLE_BITS'(mmbn_pkg::OUT_MAX_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (mmbn_pkg::cfg_idx_t'(cfg_index))
                mmbn_pkg::CFG_OUT_MIN: out_min_reg <= cfg_data;
                mmbn_pkg::CFG_OUT_MAX: out_max_reg <= cfg_data;
            endcase
        end
    end

    mmbn_store #(
        .MAX_LEN     (MAX_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .sample  (sample),
        .rd_addr (idx_reg[ADDR_W-1:0]),
        .rd_data (rd_data),
        .count   (count),
        .high    (high),
        .low     (low)
    );

    // All differences are taken one bit wider than a sample so they never overflow.
    assign range_w   = {out_max_reg[SAMPLE_BITS-1], out_max_reg}
                     - {out_min_reg[SAMPLE_BITS-1], out_min_reg};
    assign range_neg = range_w[W-1];
    assign mag       = range_neg ? (~range_w + W'(1)) : range_w;
    assign span      = {high[SAMPLE_BITS-1], high} - {low[SAMPLE_BITS-1], low};
    assign offset    = {rd_data[SAMPLE_BITS-1], rd_data} - {low[SAMPLE_BITS-1], low};
    assign product   = offset * mag;
    assign is_flat   = (high == low);

    mmbn_serial_div #(
        .W (W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (span),
        .done     (div_done),
        .quotient (quotient)
    );

    assign q_sel    = is_flat ? '0 : quotient;
    assign result_w = range_neg ? ({out_min_reg[SAMPLE_BITS-1], out_min_reg} - q_sel)
                                : ({out_min_reg[SAMPLE_BITS-1], out_min_reg} + q_sel);
    assign is_final = (idx_reg == count - CNT_W'(1));

    assign block_end = last || (count == CNT_W'(MAX_LEN - 1));

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        in_stall    = 1'b1;
        div_start   = 1'b0;
        push        = 1'b0;
        ctrl.load   = 1'b0;
        ctrl.clear  = 1'b0;
        ctrl.fetch  = 1'b0;
        unique case (state_reg)
            mmbn_pkg::ST_LOAD:
            begin
                in_stall  = 1'b0;
                ctrl.load = in_valid;
                if (in_valid && block_end)
                begin
                    idx_next   = '0;
                    state_next = mmbn_pkg::ST_FETCH;
                end
            end
            mmbn_pkg::ST_FETCH:
            begin
                ctrl.fetch = 1'b1;
                state_next = mmbn_pkg::ST_MULT;
            end
            mmbn_pkg::ST_MULT:
            begin
                if (is_flat)
                begin
                    state_next = mmbn_pkg::ST_PUSH;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = mmbn_pkg::ST_DIV;
                end
            end
            mmbn_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = mmbn_pkg::ST_PUSH;
                end
            end
            mmbn_pkg::ST_PUSH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    push = 1'b1;
                    if (is_final)
                    begin
                        ctrl.clear = 1'b1;
                        idx_next   = '0;
                        state_next = mmbn_pkg::ST_LOAD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CNT_W'(1);
                        state_next = mmbn_pkg::ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = mmbn_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mmbn_pkg::ST_LOAD;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign out_valid_next = push || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            scaled_reg   <= result_w[SAMPLE_BITS-1:0];
            flat_reg     <= is_flat;
            high_out_reg <= high;
            low_out_reg  <= low;
            eor_reg      <= is_final;
        end
    end

    assign out_valid  = out_valid_reg;
    assign scaled     = scaled_reg;
    assign flat       = flat_reg;
    assign block_high = high_out_reg;
    assign block_low  = low_out_reg;
    assign end_of_run = eor_reg;

endmodule

`default_nettype wire

// ===== tb/min_max_block_normalizer_top_tb.sv =====
// Testbench for min_max_block_normalizer_top: directed and random sample blocks with a
// self-checking block-rescaling predictor and a scoreboard of normalized words.
// Depends on mmbn_pkg and the min_max_block_normalizer_top RTL.
`timescale 1ns / 100ps

module min_max_block_normalizer_top_tb;

    localparam int STORE_DEPTH   = mmbn_pkg::MAX_LEN_DEF;
    localparam int W             = mmbn_pkg::SAMPLE_BITS_DEF;
    localparam int RANDOM_ITEMS  = 265;
    localparam int SETTLE_CYCLES = 40;
    localparam int END_CYCLES    = 50;
    localparam int DRAIN_LIMIT   = 50000;

    typedef struct packed {
        logic [W-1:0] scaled;
        logic         flat;
        logic [W-1:0] block_high;
        logic         block_low_dummy;
        logic [W-1:0] block_low;
        logic         end_of_run;
    } norm_word_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [mmbn_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [W-1:0]                   cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic [W-1:0]                   sample = '0;
    logic                           last = 1'b0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [W-1:0]                   scaled;
    logic                           flat;
    logic [W-1:0]                   block_high;
    logic [W-1:0]                   block_low;
    logic                           end_of_run;

    min_max_block_normalizer_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .scaled     (scaled),
        .flat       (flat),
        .block_high (block_high),
        .block_low  (block_low),
        .end_of_run (end_of_run)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("FAIL");
        $finish;
    end

    // Predictor state.
    logic signed [W-1:0] held_samples [STORE_DEPTH];
    int unsigned         held_count = 0;
    logic signed [W-1:0] blk_high = '0;
    logic signed [W-1:0] blk_low = '0;
    logic signed [W-1:0] target_min = W'(mmbn_pkg::OUT_MIN_RESET);
    logic signed [W-1:0] target_max = W'(mmbn_pkg::OUT_MAX_RESET);
    norm_word_t          expected_words [$];
    int                  errors = 0;

    int burst_left = 0;
    int gap_len = 0;
    int hold_req = 0;

    function automatic logic [W-1:0] rescale_sample(logic signed [W-1:0] x);
        longint offset;
        longint span;
        longint diff;
        longint mag;
        longint quot;
        longint y;
        offset = longint'(x) - longint'(blk_low);
        span   = longint'(blk_high) - longint'(blk_low);
        diff   = longint'(target_max) - longint'(target_min);
        mag    = (diff < 0) ? -diff : diff;
        quot   = (offset * mag) / span;
        y      = (diff < 0) ? longint'(target_min) - quot : longint'(target_min) + quot;
        return y[W-1:0];
    endfunction

    task automatic absorb_sample(input logic signed [W-1:0] x, input logic end_mark);
        logic       is_flat;
        norm_word_t word;
        if (held_count >= STORE_DEPTH)
            held_count = 0;
        if (held_count == 0)
        begin
            blk_high = x;
            blk_low  = x;
        end
        else
        begin
            if (x > blk_high)
                blk_high = x;
            if (x < blk_low)
                blk_low = x;
        end
        held_samples[held_count] = x;
        held_count++;
        if (!end_mark && held_count < STORE_DEPTH)
            return;
        is_flat = (blk_high == blk_low);
        for (int k = 0; k < held_count; k++)
        begin
            word = '0;
            word.scaled     = is_flat ? target_min : rescale_sample(held_samples[k]);
            word.flat       = is_flat;
            word.block_high = blk_high;
            word.block_low  = blk_low;
            word.end_of_run = (k + 1 == held_count);
            expected_words.push_back(word);
        end
        held_count = 0;
    endtask

    // Receiver: stall patterns are picked at random from four modes; a hold request stalls solidly.
    int rx_mode = 0;
    int rx_mode_left = 0;
    int rx_hold_left = 0;
    int rx_cycle = 0;

    always @(posedge clk)
    begin
        rx_cycle++;
        if (hold_req > 0)
        begin
            rx_hold_left = hold_req;
            hold_req = 0;
        end
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(8, 80);
            end
            else
                rx_mode_left--;
            case (rx_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= rx_cycle[2];
            endcase
        end
    end

    task automatic check_field(input string name, input logic [W-1:0] want,
                               input logic [W-1:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, $signed(want), $signed(got));
            errors++;
        end
    endtask

    norm_word_t want_word;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected word: scaled %0d", $signed(scaled));
                errors++;
            end
            else
            begin
                want_word = expected_words.pop_front();
                check_field("scaled", want_word.scaled, scaled);
                check_field("flat", W'(want_word.flat), W'(flat));
                check_field("block_high", want_word.block_high, block_high);
                check_field("block_low", want_word.block_low, block_low);
                check_field("end_of_run", W'(want_word.end_of_run), W'(end_of_run));
            end
        end
    end

    task automatic send_word(input logic [W-1:0] s, input logic end_mark);
        in_valid <= 1'b1;
        sample   <= s;
        last     <= end_mark;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        absorb_sample(s, end_mark);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 24);
            gap_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap_len > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap_len) @(posedge clk);
            end
        end
    endtask

    task automatic stop_sending();
        in_valid <= 1'b0;
    endtask

    task automatic wait_for_results();
        while (expected_words.size() > 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input mmbn_pkg::cfg_idx_t idx, input logic [W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == mmbn_pkg::CFG_OUT_MIN)
            target_min = data;
        else
            target_max = data;
    endtask

    task automatic config_range(input logic [W-1:0] lo_end, input logic [W-1:0] hi_end);
        stop_sending();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(mmbn_pkg::CFG_OUT_MIN, lo_end);
        write_reg(mmbn_pkg::CFG_OUT_MAX, hi_end);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_default_range();
        send_word(16'sh7FFF, 1'b0);
        send_word(16'sh8000, 1'b0);
        send_word(16'sh0000, 1'b0);
        send_word(16'sh0001, 1'b1);
        stop_sending();
    endtask

    task automatic test_full_scale_range();
        config_range(16'sh8000, 16'sh7FFF);
        send_word(16'sh8000, 1'b0);
        send_word(16'sh7FFF, 1'b0);
        send_word(16'shFFFF, 1'b0);
        send_word(16'sh0000, 1'b0);
        send_word(16'sd12345, 1'b1);
        stop_sending();
    endtask

    task automatic test_reversed_range();
        config_range(16'sh7FFF, 16'sh8000);
        send_word(16'sh7FFF, 1'b0);
        send_word(16'sh8000, 1'b0);
        send_word(16'sd5, 1'b0);
        send_word(-16'sd7, 1'b1);
        stop_sending();
    endtask

    task automatic test_flat_block();
        config_range(-16'sd500, 16'sd700);
        send_word(16'sd9, 1'b0);
        send_word(16'sd9, 1'b0);
        send_word(16'sd9, 1'b1);
        send_word(16'sh8000, 1'b1);
        stop_sending();
    endtask

    task automatic test_equal_range_ends();
        config_range(16'sd77, 16'sd77);
        send_word(16'sd1, 1'b0);
        send_word(-16'sd1000, 1'b0);
        send_word(16'sd3000, 1'b1);
        stop_sending();
    endtask

    task automatic test_output_hold();
        config_range(16'sd0, 16'sd256);
        hold_req = 600;
        repeat (30)
            send_word(W'($urandom), 1'b0);
        send_word(W'($urandom), 1'b1);
        repeat (5)
            send_word(W'($urandom), 1'b0);
        send_word(W'($urandom), 1'b1);
        stop_sending();
        wait_for_results();
    endtask

    function automatic logic [W-1:0] pick_sample(int style, logic [W-1:0] center, int spread);
        case (style)
            0: return W'($urandom);
            1: return center + W'($urandom_range(0, 2 * spread)) - W'(spread);
            default:
                case ($urandom_range(0, 4))
                    0: return 16'sh8000;
                    1: return 16'sh7FFF;
                    2: return 16'sh0000;
                    3: return 16'shFFFF;
                    default: return 16'sh0001;
                endcase
        endcase
    endfunction

    task automatic test_random_blocks();
        int           sent;
        int           blocks;
        int           kind;
        int           len;
        int           style;
        int           spread;
        logic [W-1:0] center;
        logic [W-1:0] value;
        logic         end_mark;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 7))
                0: config_range(16'sh8000, 16'sh7FFF);
                1: config_range(16'sh7FFF, 16'sh8000);
                2: config_range(16'sh8000, 16'sh8000);
                3: config_range(16'sh7FFF, 16'sh7FFF);
                4: config_range(16'sd100, -16'sd100);
                5: config_range(16'sd0, 16'sd256);
                default: config_range(W'($urandom), W'($urandom));
            endcase
            blocks = $urandom_range(3, 6);
            repeat (blocks)
            begin
                if (sent < RANDOM_ITEMS)
                begin
                    kind   = $urandom_range(0, 9);
                    style  = $urandom_range(0, 2);
                    center = W'($urandom);
                    spread = $urandom_range(1, 300);
                    if (kind <= 5)
                        len = $urandom_range(1, 10);
                    else if (kind == 6)
                        len = STORE_DEPTH;
                    else if (kind == 7)
                        len = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 13);
                    else
                        len = $urandom_range(2, 6);
                    value = pick_sample(style, center, spread);
                    for (int i = 0; i < len; i++)
                    begin
                        if (kind != 8)
                            value = pick_sample(style, center, spread);
                        if (i == len - 1)
                            end_mark = (kind == 6) ? 1'($urandom_range(0, 1)) : 1'b1;
                        else
                            end_mark = 1'b0;
                        send_word(value, end_mark);
                        sent++;
                    end
                end
            end
        end
        stop_sending();
    endtask

    initial
    begin
        int drain_cycles;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_range();
        test_full_scale_range();
        test_reversed_range();
        test_flat_block();
        test_equal_range_ends();
        test_output_hold();
        test_random_blocks();

        stop_sending();
        drain_cycles = 0;
        while (expected_words.size() > 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        if (expected_words.size() > 0)
        begin
            $error("%0d expected words never arrived", expected_words.size());
            errors++;
        end
        repeat (END_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
